### hdl/crc32_key_hash_defines.svh
// Assertion macros for the top-level file, which checks its own logic.
`ifndef CRC32_KEY_HASH_DEFINES_SVH
`define CRC32_KEY_HASH_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset
`define CHK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/crc32kh_pkg.sv
package crc32kh_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
   localparam logic [7:0]  CASE_DELTA = 8'h20;
   localparam logic [1:0]  POS_LAST   = 2'd3;

   // Register indexes on the csr port
   localparam logic REG_MODE        = 1'b0;
   localparam logic REG_START_VALUE = 1'b1;

   typedef enum logic [1:0] {
      ST_RUN = 2'b01,
      ST_PAD = 2'b10
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic step;      // fold one accepted item into the CRC
      logic pad;       // fold one padding byte into the CRC
      logic load_out;  // capture the finished CRC for the result side
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pad_needed;  // key mode and the message length is not a multiple of 4
      logic pad_last;    // current padding byte closes the group
   } sts_type;

   // One byte of reflected CRC-32, bit by bit
   function automatic logic [31:0] crc_byte(input logic [31:0] w, input logic [7:0] b);
      logic [31:0] r;
      r = w ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

### hdl/crc32kh_ctrl.sv
module crc32kh_ctrl
   import crc32kh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_tlast,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_blocked;
   logic      take_in;

   // Output register is blocked when it holds an item nobody takes this cycle
   assign out_blocked = out_valid_ff && !rsp_tready;
   assign req_tready  = (state_ff == ST_RUN) && !out_blocked;
   assign take_in     = req_tvalid && req_tready;
   assign rsp_tvalid  = out_valid_ff;

   // Issue datapath commands
   always_comb begin
      cmd.step     = take_in;
      cmd.pad      = (state_ff == ST_PAD);
      cmd.load_out = 1'b0;
      state_in     = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (take_in && req_tlast) begin
               if (sts.pad_needed) begin
                  state_in = ST_PAD;
               end else begin
                  cmd.load_out = 1'b1;
               end
            end
         end
         ST_PAD: begin
            if (sts.pad_last) begin
               cmd.load_out = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### hdl/crc32kh_dp.sv
module crc32kh_dp
   import crc32kh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   input  logic        cfg_mode,
   input  logic [31:0] cfg_start_value,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [31:0] crc
);

   logic        busy_ff, busy_in;
   logic        key_ff, key_in;
   logic [31:0] crc_ff, crc_in;
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  first_ff, first_in;
   logic        pad_first_ff, pad_first_in;
   logic [31:0] out_ff, out_in;

   logic        start;
   logic        key_cur;
   logic [31:0] base_crc;
   logic [1:0]  pos_cur;
   logic [1:0]  pos_next;
   logic [7:0]  folded;
   logic [7:0]  first_cur;
   logic [31:0] crc_step;
   logic [7:0]  pad_byte;
   logic [31:0] crc_pad;

   // Latch mode and seed at the first byte of a message
   assign start    = !busy_ff;
   assign key_cur  = start ? cfg_mode : key_ff;
   assign base_crc = start ? (cfg_mode ? CRC_INIT : ~cfg_start_value) : crc_ff;
   assign pos_cur  = start ? 2'd0 : pos_ff;
   assign pos_next = pos_cur + 2'd1;

   // Fold lower-case letters in key mode
   always_comb begin
      if (key_cur && (data_byte inside {[8'h61:8'h7A]})) begin
         folded = data_byte - CASE_DELTA;
      end else begin
         folded = data_byte;
      end
   end

   assign first_cur = (pos_cur == 2'd0) ? folded : first_ff;
   assign crc_step  = crc_byte(base_crc, folded);

   // Padding: length remainder first, then copies of the group's first byte
   assign pad_byte = pad_first_ff ? {6'd0, pos_ff} : first_ff;
   assign crc_pad  = crc_byte(crc_ff, pad_byte);

   assign sts.pad_needed = key_cur && (pos_next != 2'd0);
   assign sts.pad_last   = (pos_ff == POS_LAST);

   // Advance the working state
   always_comb begin
      busy_in      = busy_ff;
      key_in       = key_ff;
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      first_in     = first_ff;
      pad_first_in = pad_first_ff;
      out_in       = out_ff;
      if (cmd.step) begin
         busy_in      = !last_byte;
         key_in       = key_cur;
         crc_in       = crc_step;
         pos_in       = pos_next;
         first_in     = first_cur;
         pad_first_in = 1'b1;
      end else if (cmd.pad) begin
         crc_in       = crc_pad;
         pos_in       = pos_ff + 2'd1;
         pad_first_in = 1'b0;
      end
      if (cmd.load_out) begin
         out_in = cmd.pad ? ~crc_pad : ~crc_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         key_ff  <= 1'b1;
      end else begin
         busy_ff <= busy_in;
         key_ff  <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      pos_ff       <= pos_in;
      first_ff     <= first_in;
      pad_first_ff <= pad_first_in;
      out_ff       <= out_in;
   end

   assign crc = out_ff;

endmodule

### hdl/crc32_key_hash.sv
// Reflected CRC-32 (polynomial 0xEDB88320) over a byte stream, with a key-hash mode.
// req_* carries one message byte per item in req_tdata; req_tlast marks the final
// byte. rsp_* carries one finished CRC per message, after the final byte.
// csr_*: register 0 is the mode (1 key hash, 0 plain), register 1 the plain-mode
// start value; both are sampled at the first byte of each message.
// Throughput: one byte per cycle while the message streams in and the result side
// is not stalled. In key mode a message whose length is not a multiple of 4 is
// padded to a multiple of 4 at its end; no item is accepted while the padding bytes are folded.
// The CRC appears on rsp_tvalid in the cycle after the final byte, or in the cycle
// after the last padding byte.
// The result sits in an output register. While it is held and rsp_tready is low,
// req_tready is low and no byte of any kind is accepted.
// Reset returns to the start of a message with key mode and a zero start value,
// and drops any result not yet taken.
`include "crc32_key_hash_defines.svh"

module crc32_key_hash
   import crc32kh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] crc
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);

   logic        mode_ff, mode_in;
   logic [31:0] start_value_ff, start_value_in;
   cmd_type     cmd;
   sts_type     sts;

   // Write configuration registers
   always_comb begin
      mode_in        = mode_ff;
      start_value_in = start_value_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            REG_MODE:        mode_in        = csr_wdata[0];
            REG_START_VALUE: start_value_in = csr_wdata;
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b1;
         start_value_ff <= 32'd0;
      end else begin
         mode_ff        <= mode_in;
         start_value_ff <= start_value_in;
      end
   end

   crc32kh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   crc32kh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .data_byte       (req_tdata),
      .last_byte       (req_tlast),
      .cfg_mode        (mode_ff),
      .cfg_start_value (start_value_ff),
      .cmd             (cmd),
      .sts             (sts),
      .crc             (rsp_tdata)
   );

   // Checks on the controller and datapath handoff
   `CHK_NOW(a_no_accept_in_pad, cmd.pad, !req_tready, "item accepted during padding")
   `CHK_NOW(a_load_when_free, cmd.load_out, !(rsp_tvalid && !rsp_tready), "result overwritten")
   `CHK_NEXT(a_load_shows, cmd.load_out, rsp_tvalid, "loaded result not presented")
   `CHK_NEXT(a_pad_ends, cmd.pad && sts.pad_last, !cmd.pad, "padding ran past group end")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import crc32kh_pkg::*;

   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] crc
   logic        csr_wr_en = 1'b0;
   logic        csr_addr = REG_MODE;
   logic [31:0] csr_wdata = 32'd0;

   // Predictor state: register copies and the open message
   logic        cfg_mode = 1'b1;
   logic [31:0] cfg_start = 32'd0;
   logic [31:0] crc_work = CRC_INIT;
   logic [1:0]  grp_pos = 2'd0;
   logic [7:0]  grp_first = 8'd0;
   logic        msg_open = 1'b0;
   logic        key_on = 1'b1;

   logic [31:0] crc_table [256];
   logic [31:0] expected_crcs [$];
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned req_idle_pct = 7;
   int unsigned rsp_stall_pct = 7;

   crc32_key_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Byte-wise lookup table for the reflected polynomial
   initial begin
      logic [31:0] v;
      for (int i = 0; i < 256; i++) begin
         v = i;
         for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
         end
         crc_table[i] = v;
      end
   end

   function automatic logic [31:0] crc_fold(input logic [31:0] w, input logic [7:0] b);
      return (w >> 8) ^ crc_table[w[7:0] ^ b];
   endfunction

   // Advance the predictor by one accepted byte; queue the CRC at message end
   task automatic predict_byte(input logic [7:0] raw, input logic last);
      logic [7:0]  b;
      logic [31:0] w;
      if (!msg_open) begin
         key_on   = cfg_mode;
         crc_work = cfg_mode ? CRC_INIT : ~cfg_start;
         grp_pos  = 2'd0;
         msg_open = 1'b1;
      end
      b = raw;
      if (key_on && raw >= LOWER_A && raw <= LOWER_Z) begin
         b = raw - CASE_DELTA;
      end
      if (grp_pos == 2'd0) begin
         grp_first = b;
      end
      w = crc_fold(crc_work, b);
      grp_pos = grp_pos + 2'd1;
      if (!last) begin
         crc_work = w;
      end else begin
         // pad a partial group: remainder byte, then copies of its first byte
         if (key_on && grp_pos != 2'd0) begin
            w = crc_fold(w, {6'd0, grp_pos});
            for (int p = int'(grp_pos) + 1; p < 4; p++) begin
               w = crc_fold(w, grp_first);
            end
         end
         expected_crcs.push_back(~w);
         crc_work  = CRC_INIT;
         grp_pos   = 2'd0;
         grp_first = 8'd0;
         msg_open  = 1'b0;
      end
   endtask

   // Send one item; entered and left just after a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predict_byte(b, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every queued CRC, then let padding cycles pass
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_crcs.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [31:0] value);
      csr_addr  <= addr;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (addr == REG_MODE) begin
         cfg_mode = value[0];
      end else begin
         cfg_start = value;
      end
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 3))
         0:       return LOWER_A + 8'($urandom_range(0, 25));
         1:       return 8'h41 + 8'($urandom_range(0, 25));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_message();
      int unsigned len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte(pick_byte(), i == len - 1);
      end
   endtask

   // Key mode out of reset: folding limits and every padding length
   task automatic test_key_directed();
      send_byte(LOWER_A, 1'b1);
      send_byte(8'h62, 1'b0);
      send_byte(LOWER_Z, 1'b1);
      send_byte(8'h60, 1'b0);
      send_byte(8'h7B, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h5A, 1'b1);
      send_byte(LOWER_Z, 1'b0);
      send_byte(LOWER_A, 1'b0);
      send_byte(8'hC1, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFE, 1'b1);
      wait_idle();
   endtask

   // Plain mode at both extremes of the start value
   task automatic test_plain_directed();
      write_reg(REG_MODE, 32'd0);
      write_reg(REG_START_VALUE, 32'd0);
      send_byte(LOWER_A, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b1);
      wait_idle();
      write_reg(REG_START_VALUE, 32'hFFFF_FFFF);
      send_byte(8'hFF, 1'b1);
      wait_idle();
   endtask

   // Registers written inside a message must not affect it
   task automatic test_mode_change_mid_message();
      write_reg(REG_MODE, 32'd1);
      send_byte(8'h71, 1'b0);
      send_byte(8'h77, 1'b0);
      wait_idle();
      write_reg(REG_MODE, 32'd0);
      write_reg(REG_START_VALUE, 32'h1234_5678);
      send_byte(8'h65, 1'b0);
      send_byte(8'h72, 1'b1);
      send_byte(8'h79, 1'b1);
      wait_idle();
      send_byte(8'h6B, 1'b0);
      wait_idle();
      write_reg(REG_MODE, 32'd1);
      send_byte(8'h70, 1'b1);
      wait_idle();
   endtask

   // Random phases; each phase gets fresh register values
   task automatic run_random_phases(input int unsigned phases, input int unsigned bytes_each);
      int unsigned target;
      logic [31:0] sv;
      for (int unsigned ph = 0; ph < phases; ph++) begin
         case ($urandom_range(0, 3))
            0:       sv = 32'd0;
            1:       sv = 32'hFFFF_FFFF;
            default: sv = $urandom();
         endcase
         write_reg(REG_MODE, 32'($urandom_range(0, 1)));
         write_reg(REG_START_VALUE, sv);
         target = bytes_sent + bytes_each;
         while (bytes_sent < target) begin
            send_random_message();
         end
         wait_idle();
      end
   endtask

   task automatic test_random_key();
      write_reg(REG_MODE, 32'd1);
      repeat (60) send_random_message();
      wait_idle();
   endtask

   // Long stretch with no idling on either side
   task automatic test_random_back_to_back();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_random_phases(4, 130);
      req_idle_pct  = 7;
      rsp_stall_pct = 7;
   endtask

   task automatic test_random_mixed();
      run_random_phases(10, 100);
   endtask

   // Randomly stall the result side
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Compare each accepted CRC with the oldest expectation
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_crcs.size() == 0) begin
            $error("crc: expected none, actual %08h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_crcs.pop_front();
            if (rsp_tdata !== want) begin
               $error("crc: expected %08h, actual %08h", want, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_key_directed();
      test_plain_directed();
      test_mode_change_mid_message();
      test_random_key();
      test_random_back_to_back();
      test_random_mixed();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_crcs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### crc32_key_hash.f
+incdir+hdl
hdl/crc32kh_pkg.sv
hdl/crc32kh_ctrl.sv
hdl/crc32kh_dp.sv
hdl/crc32_key_hash.sv
tb/sv/tb.sv
